// File: rtl/core/dpbt_pkg.sv
package dpbt_pkg;

    localparam int ENV_W   = 16;
    localparam int SCORE_W = 48;
    localparam int LN_W    = 16;
    localparam int BEAT_W  = 12;
    localparam int CFG_W   = 16;
    localparam int PER_W   = 9;

    localparam logic [63:0] LN2_Q32 = 64'd2977044472;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_TIGHT  = 1'b1;

    // Natural logarithm in Q4.12, via a base-two logarithm with a 20-bit fraction.
    function automatic logic [LN_W-1:0] ln_q12(input int unsigned x);
        int unsigned k;
        logic [63:0] m;
        logic [63:0] lg;
        logic [63:0] prod;
        k = 0;
        lg = '0;
        if (x <= 1) begin
            return '0;
        end
        for (int j = 1; j < 32; j++) begin
            if ((x >> j) != 0) begin
                k = j;
            end
        end
        m = 64'(x) << (31 - k);
        for (int s = 0; s < 20; s++) begin
            m = (m * m) >> 31;
            lg = lg << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                lg = lg | 64'd1;
            end
        end
        lg = lg | (64'(k) << 20);
        prod = (lg * LN2_Q32) + (64'd1 << 39);
        return LN_W'(prod >> 40);
    endfunction

endpackage

// File: rtl/core/dpbt_ln_rom.sv
module dpbt_ln_rom #(
    parameter int MAX_PERIOD = 512
) (
    input  logic                              i_clk,
    input  logic [$clog2(MAX_PERIOD+1):0]     i_addr,
    output logic [dpbt_pkg::LN_W-1:0]         o_data
);
    import dpbt_pkg::*;

    localparam int ROM_SIZE = 2 * MAX_PERIOD + 1;

    logic [LN_W-1:0] w_rom [ROM_SIZE];
    logic [LN_W-1:0] r_data;

    for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
        localparam logic [LN_W-1:0] LnVal = ln_q12(g);
        assign w_rom[g] = LnVal;
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

// File: rtl/core/dp_beat_tracker.sv
// Beat tracker over an onset envelope. Load requests write one envelope frame each and are
// taken one per cycle while no read is pending. A load marked last starts the dynamic
// program, during which no request is taken: for each frame it scans w predecessors (at most
// 2P - ceil(P/2) + 1 for period P) through the single read port of the frame memory, which
// returns one predecessor score per cycle into a cost pipeline. The backtrace then reads each
// beat's link and writes the beat to the beat list in turn. Read requests return the beats in
// ascending frame order, one result each; the input stalls after each read request until its
// result moves into the output register, which waits while the output is stalled.
module dp_beat_tracker #(
    parameter int MAX_FRAMES = 4096,
    parameter int MAX_PERIOD = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [dpbt_pkg::ENV_W-1:0]    i_onset_value,
    input  logic                          i_last_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dpbt_pkg::BEAT_W-1:0]   o_beat_frame,
    output logic                          o_last_beat,
    output logic                          o_beat_valid,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [dpbt_pkg::CFG_W-1:0]    i_cfg_data
);
    import dpbt_pkg::*;

    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int CW  = FW + 1;
    localparam int PW  = $clog2(MAX_PERIOD + 1);
    localparam int OW  = PW + 1;
    localparam int WW  = (FW > OW) ? FW : OW;

    typedef struct packed {
        logic [ENV_W-1:0]          env;
        logic signed [SCORE_W-1:0] score;
        logic                      ok;
        logic [FW-1:0]             link;
    } t_fword;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LNP   = 9'b000000010,
        S_FRAME = 9'b000000100,
        S_ENV   = 9'b000001000,
        S_SCAN  = 9'b000010000,
        S_DRAIN = 9'b000100000,
        S_WRITE = 9'b001000000,
        S_BT_RD = 9'b010000000,
        S_BT_WR = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [PER_W-1:0] r_cfg_period;
    logic [CFG_W-1:0] r_cfg_tight;

    t_fword r_fmem [MAX_FRAMES];
    t_fword r_frd;
    logic [BEAT_W-1:0] r_blist [MAX_FRAMES];
    logic [BEAT_W-1:0] r_beat_q;

    logic [CW-1:0] r_fc, r_n, r_bc, r_rp;
    logic [FW-1:0] r_i, r_t, r_end;
    logic signed [SCORE_W-1:0] r_end_sc;
    logic [PW-1:0] r_p;
    logic [CFG_W-1:0] r_tight;
    logic [OW-1:0] r_off;
    logic r_nopred;
    logic [ENV_W-1:0] r_env;
    logic [LN_W-1:0] r_ln_p;

    logic r_v1, r_v2, r_v3, r_v4;
    logic [FW-1:0] r_tau1, r_tau2, r_tau3, r_tau4;
    logic signed [SCORE_W-1:0] r_sc2, r_sc3, r_sc4;
    logic signed [LN_W:0] r_d2;
    logic [23:0] r_sq3;
    logic [24:0] r_cost4;

    logic r_found;
    logic signed [SCORE_W-1:0] r_best;
    logic [FW-1:0] r_btau;

    logic r_rd_pend, r_rd_valid, r_rd_last;
    logic r_out_valid, r_out_last, r_out_bv;
    logic [BEAT_W-1:0] r_out_frame;

    logic [LN_W-1:0] w_ln;
    logic [OW-1:0] w_rom_addr;
    logic [PW-1:0] w_p_clamp;
    logic [OW-1:0] w_off_hi, w_off_lo;
    logic [FW-1:0] w_tau;
    logic [FW-1:0] w_frd_addr;
    logic w_in_acc, w_out_load, w_fc_room;
    logic [CW-1:0] w_fc_next;
    logic [33:0] w_sq34;
    logic [39:0] w_prod;
    logic [40:0] w_cost_r;
    logic signed [SCORE_W-1:0] w_s, w_local, w_score;
    logic [FW-1:0] w_end;
    logic [CW-1:0] w_baddr;

    always_comb begin
        if (r_cfg_period == '0) begin
            w_p_clamp = PW'(1);
        end else if (32'(r_cfg_period) > MAX_PERIOD) begin
            w_p_clamp = PW'(MAX_PERIOD);
        end else begin
            w_p_clamp = PW'(r_cfg_period);
        end
    end

    assign w_off_hi = {r_p, 1'b0};
    assign w_off_lo = OW'((OW'(r_p) + OW'(1)) >> 1);
    assign w_tau    = FW'(WW'(r_i) - WW'(r_off));

    assign w_rom_addr = (r_state == S_LNP) ? OW'(w_p_clamp) : r_off;

    dpbt_ln_rom #(
        .MAX_PERIOD(MAX_PERIOD)
    ) u_ln_rom (
        .i_clk (i_clk),
        .i_addr(w_rom_addr),
        .o_data(w_ln)
    );

    assign o_in_stall = (r_state != S_IDLE) || r_rd_pend;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_load = r_rd_pend && (!r_out_valid || !i_out_stall);
    assign w_fc_room  = (r_fc != CW'(MAX_FRAMES));
    assign w_fc_next  = w_fc_room ? r_fc + CW'(1) : r_fc;
    assign w_baddr    = r_bc - CW'(1) - r_rp;

    always_comb begin
        unique case (r_state)
            S_SCAN:  w_frd_addr = w_tau;
            S_BT_RD: w_frd_addr = r_t;
            default: w_frd_addr = r_i;
        endcase
    end

    assign w_sq34   = $unsigned(34'(r_d2 * r_d2));
    assign w_prod   = 40'(r_tight) * 40'(r_sq3);
    assign w_cost_r = {1'b0, w_prod} + 41'd32768;
    assign w_s      = r_sc4 - $signed(SCORE_W'(r_cost4));
    assign w_local  = $signed(SCORE_W'({r_env, 8'h00}));
    assign w_score  = (r_found ? r_best : '0) + w_local;
    assign w_end    = ((r_i == '0) || (w_score > r_end_sc)) ? r_i : r_end;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_func == FUNC_LOAD) && i_last_sample) begin
                    n_state = S_LNP;
                end
            end
            S_LNP:   n_state = S_FRAME;
            S_FRAME: n_state = S_ENV;
            S_ENV:   n_state = r_nopred ? S_WRITE : S_SCAN;
            S_SCAN: begin
                if (r_off == w_off_lo) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!(r_v1 || r_v2 || r_v3 || r_v4)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = ((CW'(r_i) + CW'(1)) == r_n) ? S_BT_RD : S_FRAME;
            S_BT_RD: n_state = S_BT_WR;
            S_BT_WR: n_state = r_frd.ok ? S_BT_RD : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_period <= PER_W'(43);
            r_cfg_tight  <= CFG_W'(25600);
            r_fc         <= '0;
            r_bc         <= '0;
            r_rp         <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PERIOD: r_cfg_period <= i_cfg_data[PER_W-1:0];
                    CFG_TIGHT:  r_cfg_tight  <= i_cfg_data;
                    default:    r_cfg_tight  <= r_cfg_tight;
                endcase
            end
            r_v1 <= (r_state == S_SCAN);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (w_in_acc && (i_func == FUNC_LOAD)) begin
                r_fc <= w_fc_next;
            end
            if (w_in_acc && (i_func == FUNC_READ)) begin
                r_rd_pend <= 1'b1;
                if (r_rp < r_bc) begin
                    r_rp <= r_rp + CW'(1);
                end
            end else if (w_out_load) begin
                r_rd_pend <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_LNP) begin
                r_fc <= '0;
                r_rp <= '0;
                r_bc <= '0;
            end
            if (r_state == S_BT_WR) begin
                r_bc <= r_bc + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_frd <= r_fmem[w_frd_addr];
        if (w_in_acc && (i_func == FUNC_LOAD) && w_fc_room) begin
            r_fmem[r_fc[FW-1:0]] <= '{env: i_onset_value, score: '0, ok: 1'b0, link: '0};
        end else if (r_state == S_WRITE) begin
            r_fmem[r_i] <= '{env: r_env, score: w_score, ok: r_found, link: r_btau};
        end
        if (r_state == S_BT_WR) begin
            r_blist[r_bc[FW-1:0]] <= BEAT_W'(r_t);
        end
        if (w_in_acc && (i_func == FUNC_READ)) begin
            r_beat_q   <= r_blist[w_baddr[FW-1:0]];
            r_rd_valid <= (r_rp < r_bc);
            r_rd_last  <= (r_rp < r_bc) && ((r_rp + CW'(1)) == r_bc);
        end
        if (w_out_load) begin
            r_out_frame <= r_rd_valid ? r_beat_q : '0;
            r_out_last  <= r_rd_last;
            r_out_bv    <= r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tau1  <= w_tau;
        r_tau2  <= r_tau1;
        r_sc2   <= r_frd.score;
        r_d2    <= $signed({1'b0, w_ln}) - $signed({1'b0, r_ln_p});
        r_tau3  <= r_tau2;
        r_sc3   <= r_sc2;
        r_sq3   <= w_sq34[23:0];
        r_tau4  <= r_tau3;
        r_sc4   <= r_sc3;
        r_cost4 <= w_cost_r[40:16];
        if (r_v4 && (!r_found || (w_s > r_best))) begin
            r_best  <= w_s;
            r_btau  <= r_tau4;
            r_found <= 1'b1;
        end
        if (w_in_acc && (i_func == FUNC_LOAD) && i_last_sample) begin
            r_n <= w_fc_next;
        end
        unique case (r_state)
            S_LNP: begin
                r_p     <= w_p_clamp;
                r_tight <= r_cfg_tight;
                r_i     <= '0;
            end
            S_FRAME: begin
                r_found <= 1'b0;
                if (r_i == '0) begin
                    r_ln_p <= w_ln;
                end
                if (WW'(r_i) >= WW'(w_off_hi)) begin
                    r_off <= w_off_hi;
                end else begin
                    r_off <= OW'(r_i);
                end
                r_nopred <= (WW'(r_i) < WW'(w_off_lo));
            end
            S_ENV: r_env <= r_frd.env;
            S_SCAN: begin
                if (r_off != w_off_lo) begin
                    r_off <= r_off - OW'(1);
                end
            end
            S_WRITE: begin
                r_end    <= w_end;
                r_end_sc <= ((r_i == '0) || (w_score > r_end_sc)) ? w_score : r_end_sc;
                r_i      <= r_i + FW'(1);
                r_t      <= w_end;
            end
            S_BT_WR: r_t <= r_frd.link;
            default: r_t <= r_t;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_beat_frame = r_out_frame;
    assign o_last_beat  = r_out_last;
    assign o_beat_valid = r_out_bv;

endmodule

// File: sim/dp_beat_tracker_test.sv
`timescale 1ns / 1ps

module dp_beat_tracker_test;

    import dpbt_pkg::*;

    localparam int N_FRAMES   = 4096;
    localparam int TOP_PERIOD = 512;
    localparam int IDLE_LIMIT = 200000;
    localparam int RANDOM_REQ = 1000;

    typedef struct {
        logic              func;
        logic [ENV_W-1:0]  onset;
        logic              last;
        bit                typed;
        logic [BEAT_W-1:0] frame;
        logic              last_beat;
        logic              beat_ok;
    } t_stim_row;

    typedef struct {
        logic [BEAT_W-1:0] frame;
        logic              last_beat;
        logic              beat_ok;
    } t_beat_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_func;
    logic [ENV_W-1:0]  i_onset_value;
    logic              i_last_sample;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [BEAT_W-1:0] o_beat_frame;
    logic              o_last_beat;
    logic              o_beat_valid;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    // Predictor state.
    int          ln_tab [0:2*TOP_PERIOD+1];
    logic [15:0] env_mem [N_FRAMES];
    longint      score_mem [N_FRAMES];
    int          link_mem [N_FRAMES];
    bit          has_link [N_FRAMES];
    int          beat_mem [N_FRAMES];
    int          frames_held;
    int          beats_found;
    int          beats_read;
    int          period_reg;
    int          tight_reg;

    t_beat_res   beat_q[$];
    int          errors;
    int          sent;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          pressure;
    int          hold_left;
    bit          held;
    int          quiet_cycles;

    dp_beat_tracker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_onset_value (i_onset_value),
        .i_last_sample (i_last_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_beat_frame  (o_beat_frame),
        .o_last_beat   (o_last_beat),
        .o_beat_valid  (o_beat_valid),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Natural logarithm in Q4.12 from a base-two logarithm with a 20-bit fraction.
    function automatic int log_q12(input int unsigned x);
        int unsigned    e;
        bit [63:0]      mant;
        bit [63:0]      frac;
        e = 0;
        frac = 0;
        if (x <= 1) begin
            return 0;
        end
        while (e < 31 && (x >> (e + 1)) != 0) begin
            e++;
        end
        mant = 64'(x) << (31 - e);
        repeat (20) begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000) begin
                mant = mant >> 1;
                frac[0] = 1'b1;
            end
        end
        frac = frac | (64'(e) << 20);
        return int'((frac * 64'd2977044472 + (64'd1 << 39)) >> 40);
    endfunction

    function automatic void track_beats();
        int     p;
        int     lo;
        int     hi;
        int     tail;
        int     t;
        int     cnt;
        int     d;
        longint best;
        longint cand;
        longint cost;
        bit     found;
        int     best_tau;
        p = (period_reg == 0) ? 1 : period_reg;
        if (p > TOP_PERIOD) begin
            p = TOP_PERIOD;
        end
        hi = 2 * p;
        lo = (p + 1) / 2;
        for (int i = 0; i < frames_held; i++) begin
            found = 0;
            best = 0;
            best_tau = 0;
            for (int off = hi; off >= lo && off >= 1; off--) begin
                if (off <= i) begin
                    d = ln_tab[off] - ln_tab[p];
                    cost = (longint'(tight_reg) * longint'(d) * longint'(d) + 32768) >>> 16;
                    cand = score_mem[i - off] - cost;
                    if (!found || cand > best) begin
                        best = cand;
                        best_tau = i - off;
                        found = 1;
                    end
                end
            end
            score_mem[i] = (found ? best : 0) + (longint'(env_mem[i]) << 8);
            link_mem[i] = best_tau;
            has_link[i] = found;
        end
        beats_found = 0;
        beats_read = 0;
        if (frames_held == 0) begin
            return;
        end
        tail = 0;
        for (int i = 1; i < frames_held; i++) begin
            if (score_mem[i] > score_mem[tail]) begin
                tail = i;
            end
        end
        cnt = 1;
        t = tail;
        while (has_link[t]) begin
            t = link_mem[t];
            cnt++;
        end
        t = tail;
        for (int i = cnt - 1; i >= 0; i--) begin
            beat_mem[i] = t;
            t = link_mem[t];
        end
        beats_found = cnt;
        frames_held = 0;
    endfunction

    function automatic bit apply_request(input logic f, input logic [ENV_W-1:0] v,
                                         input logic l, output t_beat_res r);
        r = '{frame: '0, last_beat: 1'b0, beat_ok: 1'b0};
        if (f == FUNC_LOAD) begin
            if (frames_held < N_FRAMES) begin
                env_mem[frames_held] = v;
                frames_held++;
            end
            if (l) begin
                track_beats();
            end
            return 0;
        end
        if (beats_read < beats_found) begin
            r.frame = BEAT_W'(beat_mem[beats_read]);
            r.last_beat = (beats_read + 1 == beats_found);
            r.beat_ok = 1'b1;
            beats_read++;
        end
        return 1;
    endfunction

    task automatic send_request(input t_stim_row row);
        t_beat_res r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= row.func;
        i_onset_value <= row.onset;
        i_last_sample <= row.last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sent++;
        if (apply_request(row.func, row.onset, row.last, r)) begin
            if (row.typed) begin
                r = '{frame: row.frame, last_beat: row.last_beat, beat_ok: row.beat_ok};
            end
            beat_q = {beat_q, r};
        end
    endtask

    task automatic send_plain(input logic f, input logic [ENV_W-1:0] v, input logic l);
        send_request('{func: f, onset: v, last: l, typed: 0,
                       frame: '0, last_beat: 1'b0, beat_ok: 1'b0});
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (beat_q.size() != 0) begin
            @(posedge i_clk);
        end
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PERIOD) begin
            period_reg = value & 32'h1FF;
        end else begin
            tight_reg = value & 32'hFFFF;
        end
    endtask

    // One envelope: loads with the odd read or early last mark in between, then the beat list.
    task automatic run_envelope(input int n, input int mix_pct);
        logic [ENV_W-1:0] v;
        int               reads;
        for (int i = 0; i < n; i++) begin
            while ($urandom_range(99) < mix_pct) begin
                send_plain(FUNC_READ, ENV_W'($urandom), 1'($urandom));
            end
            case ($urandom_range(7))
                0: v = '0;
                1: v = '1;
                default: v = ENV_W'($urandom);
            endcase
            send_plain(FUNC_LOAD, v, (i == n - 1) ? 1'b1 : (mix_pct > 0 && $urandom_range(49) == 0));
        end
        reads = beats_found - beats_read;
        if (reads > 60) begin
            reads = 60;
        end
        reads += $urandom_range(3) + 1;
        repeat (reads) begin
            send_plain(FUNC_READ, ENV_W'($urandom), 1'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        t_beat_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (beat_q.size() == 0) begin
                $display("%0t: unexpected result frame %0d last %0d valid %0d", $time,
                         o_beat_frame, o_last_beat, o_beat_valid);
                errors++;
            end else begin
                want = beat_q.pop_front();
                if (o_beat_frame !== want.frame) begin
                    $display("%0t: beat_frame expected %0d actual %0d", $time,
                             want.frame, o_beat_frame);
                    errors++;
                end
                if (o_last_beat !== want.last_beat) begin
                    $display("%0t: last_beat expected %0d actual %0d", $time,
                             want.last_beat, o_last_beat);
                    errors++;
                end
                if (o_beat_valid !== want.beat_ok) begin
                    $display("%0t: beat_valid expected %0d actual %0d", $time,
                             want.beat_ok, o_beat_valid);
                    errors++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (pressure && !held) begin
            held <= 1'b1;
            hold_left <= 400;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("dp_beat_tracker test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_stim_row rows [18];
        int        start;
        int        p;
        int        n;
        int        env_no;
        errors = 0;
        sent = 0;
        held = 0;
        hold_left = 0;
        pressure = 0;
        quiet_cycles = 0;
        send_idle_pct = 30;
        recv_stall_pct = 83;
        frames_held = 0;
        beats_found = 0;
        beats_read = 0;
        period_reg = 43;
        tight_reg = 25600;
        for (int x = 0; x <= 2 * TOP_PERIOD + 1; x++) begin
            ln_tab[x] = log_q12(x);
        end
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_func <= FUNC_LOAD;
        i_onset_value <= '0;
        i_last_sample <= 1'b0;
        i_out_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_PERIOD;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{FUNC_READ, 16'h0000, 1'b0, 1, 12'd0, 1'b0, 1'b0},
            '{FUNC_READ, 16'hFFFF, 1'b1, 1, 12'd0, 1'b0, 1'b0},
            '{FUNC_LOAD, 16'hFFFF, 1'b1, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_READ, 16'h0000, 1'b0, 1, 12'd0, 1'b1, 1'b1},
            '{FUNC_READ, 16'h0000, 1'b0, 1, 12'd0, 1'b0, 1'b0},
            '{FUNC_LOAD, 16'h0000, 1'b0, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_LOAD, 16'hFFFF, 1'b0, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_LOAD, 16'h0001, 1'b0, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_LOAD, 16'h8000, 1'b0, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_READ, 16'h5A5A, 1'b1, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_LOAD, 16'h00FF, 1'b0, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_LOAD, 16'hFF00, 1'b0, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_LOAD, 16'h1234, 1'b0, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_LOAD, 16'h4321, 1'b1, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_READ, 16'h0000, 1'b0, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_READ, 16'h0000, 1'b0, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_READ, 16'hA5A5, 1'b1, 0, 12'd0, 1'b0, 1'b0},
            '{FUNC_READ, 16'h0000, 1'b0, 0, 12'd0, 1'b0, 1'b0}
        };
        foreach (rows[k]) begin
            send_request(rows[k]);
        end

        // Period zero behaves as one; then the largest period with the heaviest weight.
        write_reg(CFG_PERIOD, 0);
        write_reg(CFG_TIGHT, 0);
        run_envelope(6, 0);
        write_reg(CFG_PERIOD, 511);
        write_reg(CFG_TIGHT, 65535);
        run_envelope(5, 0);
        write_reg(CFG_PERIOD, 2);
        run_envelope(12, 0);

        start = sent;
        env_no = 0;
        while (sent - start < RANDOM_REQ) begin
            if (sent - start < RANDOM_REQ / 3) begin
                send_idle_pct = 30;
                recv_stall_pct = 83;
            end else if (sent - start < 2 * RANDOM_REQ / 3) begin
                send_idle_pct = 83;
                recv_stall_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if (env_no % 3 == 0) begin
                case ($urandom_range(9))
                    0: p = 0;
                    1: p = $urandom_range(256, 511);
                    2, 3: p = $urandom_range(17, 64);
                    default: p = $urandom_range(1, 16);
                endcase
                write_reg(CFG_PERIOD, p);
                case ($urandom_range(5))
                    0: write_reg(CFG_TIGHT, 0);
                    1: write_reg(CFG_TIGHT, 65535);
                    default: write_reg(CFG_TIGHT, $urandom_range(65535));
                endcase
            end
            n = (period_reg > 64) ? $urandom_range(1, 20) : $urandom_range(1, 48);
            run_envelope(n, ($urandom_range(3) == 0) ? 15 : 3);
            if (!pressure && send_idle_pct == 0) begin
                pressure = 1;
                repeat (40) send_plain(FUNC_READ, ENV_W'($urandom), 1'b0);
            end
            env_no++;
        end

        i_in_valid <= 1'b0;
        while (beat_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("dp_beat_tracker test passed");
        end else begin
            $display("dp_beat_tracker test failed");
        end
        $finish;
    end

endmodule
